// ===== rtl/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// ssl_pkg
// Types and constants shared by the superstring length block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssl_pkg;

  localparam int unsigned MAX_STRINGS_DEF = 8;
  localparam int unsigned MAX_LEN_DEF     = 128;
  localparam int unsigned SUM_W           = 11;

  // input word
  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_empty;
    logic       end_of_string;
    logic       end_of_set;
  } ssl_in_t;

  // result word
  typedef struct packed {
    logic [SUM_W-1:0] superstring_length;
    logic             overflow_flag;
  } ssl_out_t;

  // controller states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PA,
    ST_PB,
    ST_KINIT,
    ST_RD,
    ST_CMP,
    ST_SINIT,
    ST_TRY,
    ST_ADD,
    ST_DONE
  } ssl_state_t;

endpackage

// ===== rtl/shortest_superstring_length.sv =====
// ----------------------------------------------------------------------------
// shortest_superstring_length
// Loads a string set and returns its shortest common superstring length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Bytes load one word per cycle into the character memory. The word that ends
// the set holds in_ready low while the block compares every ordered pair of
// strings (states PA, PB and KINIT set up each pair, then RD and CMP handle
// each byte compared through the two-port character memory, at most about
// n*n*L*L/2 byte compares for n strings of up to L bytes) and then walks the
// tree of string orders (a TRY step for every candidate scanned at a node,
// placed or not, and an ADD step for every branch taken, with one overlap
// memory read each). A set that overflows skips both searches. The result is
// then registered in the output register once the previous result has been
// taken; loading of the next set starts right after that.
module shortest_superstring_length #(
  parameter int unsigned MAX_STRINGS = ssl_pkg::MAX_STRINGS_DEF,
  parameter int unsigned MAX_LEN     = ssl_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssl_pkg::ssl_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ssl_pkg::ssl_out_t out_data
);
  import ssl_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_STRINGS + 1);
  localparam int unsigned IW  = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned CD  = MAX_STRINGS * MAX_LEN;
  localparam int unsigned AW  = (CD > 1) ? $clog2(CD) : 1;
  localparam int unsigned OD  = MAX_STRINGS * MAX_STRINGS;
  localparam int unsigned OAW = (OD > 1) ? $clog2(OD) : 1;

  // memories
  logic [7:0]  ch_mem [CD];
  logic [7:0]  ov_mem [OD];
  logic [7:0]  qa_r, qb_r, ov_q_r;

  // small stores
  logic [LW-1:0]    lens_r  [MAX_STRINGS];
  logic [CW-1:0]    cur_r   [MAX_STRINGS];
  logic [SUM_W-1:0] sum_r   [MAX_STRINGS];
  logic [IW-1:0]    order_r [MAX_STRINGS];

  ssl_state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [LW-1:0]    cur_len_r, cur_len_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [LW-1:0]    la_r, la_nxt, lb_r, lb_nxt, k_r, k_nxt, t_r, t_nxt;
  logic [CW-1:0]    d_r, d_nxt;
  logic [MAX_STRINGS-1:0] used_r, used_nxt;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic             out_valid_r, out_valid_nxt;
  ssl_out_t         out_data_r, out_data_nxt;

  // strobes and addresses
  logic             ch_we, len_we, ov_we, stk_adv, stk_push;
  logic [AW-1:0]    ch_wa, ra_a, ra_b;
  logic [IW-1:0]    len_wa;
  logic [OAW-1:0]   ov_wa, ov_ra;
  logic [7:0]       ov_wd;
  logic [IW-1:0]    d_idx, dm1_idx, dp1_idx, i_idx;
  logic [CW-1:0]    cand;
  logic [SUM_W-1:0] new_sum;
  logic [LW-1:0]    len_inc;
  logic             closing, full;

  assign d_idx   = d_r[IW-1:0];
  assign dm1_idx = IW'(d_r - CW'(1));
  assign dp1_idx = IW'(d_r + CW'(1));
  assign cand    = cur_r[d_idx];
  assign i_idx   = cand[IW-1:0];
  assign new_sum = sum_r[d_idx] + ((d_r == '0) ? SUM_W'(0) : SUM_W'(ov_q_r));
  assign full    = (count_r == CW'(MAX_STRINGS));
  assign closing = in_data.string_empty | in_data.end_of_string | in_data.end_of_set;
  assign len_inc = cur_len_r + LW'(1);

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      cur_len_r   <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_len_r   <= cur_len_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    used_r     <= used_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  // character and overlap memories
  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[ch_wa] <= in_data.char_byte;
    end
    qa_r <= ch_mem[ra_a];
    qb_r <= ch_mem[ra_b];
    if (ov_we) begin
      ov_mem[ov_wa] <= ov_wd;
    end
    ov_q_r <= ov_mem[ov_ra];
  end

  // length table and search stack
  always_ff @(posedge clk) begin
    if (len_we) begin
      lens_r[len_wa] <= cur_len_nxt == '0 && !(!in_data.string_empty && !full &&
                        cur_len_r < LW'(MAX_LEN)) ? cur_len_r :
                        ((!in_data.string_empty && cur_len_r < LW'(MAX_LEN)) ?
                         len_inc : cur_len_r);
    end
    if (stk_adv) begin
      cur_r[d_idx] <= cand + CW'(1);
    end
    if (stk_push) begin
      order_r[d_idx]   <= i_idx;
      sum_r[dp1_idx]   <= new_sum;
      cur_r[dp1_idx]   <= '0;
    end
    if (state_r == ST_SINIT) begin
      cur_r[0] <= '0;
      sum_r[0] <= '0;
    end
  end

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_len_nxt   = cur_len_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    used_nxt      = used_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    ch_we         = 1'b0;
    ch_wa         = AW'(32'(count_r[IW-1:0]) * MAX_LEN + 32'(cur_len_r));
    len_we        = 1'b0;
    len_wa        = count_r[IW-1:0];
    ov_we         = 1'b0;
    ov_wa         = OAW'(32'(a_r[IW-1:0]) * MAX_STRINGS + 32'(b_r[IW-1:0]));
    ov_wd         = '0;
    ov_ra         = OAW'(32'(order_r[dm1_idx]) * MAX_STRINGS + 32'(i_idx));
    ra_a          = AW'(32'(a_r[IW-1:0]) * MAX_LEN + 32'(la_r - k_r + t_r));
    ra_b          = AW'(32'(b_r[IW-1:0]) * MAX_LEN + 32'(t_r));
    stk_adv       = 1'b0;
    stk_push      = 1'b0;

    case (state_r)
      // load one word per cycle
      ST_LOAD: begin
        if (in_valid) begin
          if (!in_data.string_empty && !full) begin
            if (cur_len_r < LW'(MAX_LEN)) begin
              ch_we       = 1'b1;
              cur_len_nxt = len_inc;
              total_nxt   = total_r + SUM_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (closing) begin
            if (!full) begin
              len_we      = 1'b1;
              count_nxt   = count_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            cur_len_nxt = '0;
          end
          if (in_data.end_of_set) begin
            a_nxt     = '0;
            b_nxt     = '0;
            state_nxt = (ovf_nxt) ? ST_DONE : ST_PA;
          end
        end
      end
      // walk ordered pairs, fetch first length
      ST_PA: begin
        if (a_r == count_r) begin
          state_nxt = ST_SINIT;
        end else if (b_r == count_r) begin
          a_nxt = a_r + CW'(1);
          b_nxt = '0;
        end else if (a_r == b_r) begin
          b_nxt = b_r + CW'(1);
        end else begin
          la_nxt    = lens_r[a_r[IW-1:0]];
          state_nxt = ST_PB;
        end
      end
      ST_PB: begin
        lb_nxt    = lens_r[b_r[IW-1:0]];
        state_nxt = ST_KINIT;
      end
      // start with the longest candidate overlap
      ST_KINIT: begin
        k_nxt = (la_r < lb_r) ? la_r : lb_r;
        t_nxt = '0;
        if (k_nxt == '0) begin
          ov_we     = 1'b1;
          b_nxt     = b_r + CW'(1);
          state_nxt = ST_PA;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      // compare one byte pair
      ST_CMP: begin
        if (qa_r == qb_r) begin
          if (t_r == k_r - LW'(1)) begin
            ov_we     = 1'b1;
            ov_wd     = 8'(k_r);
            b_nxt     = b_r + CW'(1);
            state_nxt = ST_PA;
          end else begin
            t_nxt     = t_r + LW'(1);
            state_nxt = ST_RD;
          end
        end else begin
          k_nxt = k_r - LW'(1);
          t_nxt = '0;
          if (k_nxt == '0) begin
            ov_we     = 1'b1;
            b_nxt     = b_r + CW'(1);
            state_nxt = ST_PA;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_SINIT: begin
        d_nxt     = '0;
        used_nxt  = '0;
        best_nxt  = '0;
        state_nxt = ST_TRY;
      end
      // pick next candidate at this depth, or back up
      ST_TRY: begin
        if (cand >= count_r) begin
          if (d_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            d_nxt                     = d_r - CW'(1);
            used_nxt[order_r[dm1_idx]] = 1'b0;
          end
        end else if (used_r[i_idx]) begin
          stk_adv = 1'b1;
        end else begin
          state_nxt = ST_ADD;
        end
      end
      // add overlap, record leaf or descend
      ST_ADD: begin
        stk_adv = 1'b1;
        if (d_r + CW'(1) == count_r) begin
          if (new_sum > best_r) begin
            best_nxt = new_sum;
          end
        end else begin
          stk_push         = 1'b1;
          used_nxt[i_idx]  = 1'b1;
          d_nxt            = d_r + CW'(1);
        end
        state_nxt = ST_TRY;
      end
      // hand over result, clear set state
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.overflow_flag      = ovf_r;
          out_data_nxt.superstring_length = ovf_r ? '0 : total_r - best_r;
          count_nxt   = '0;
          cur_len_nxt = '0;
          total_nxt   = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== verif/tb_shortest_superstring_length.sv =====
// ----------------------------------------------------------------------------
// tb_shortest_superstring_length
// Self-checking bench for the superstring length block: loads string sets,
// predicts each set's superstring length and overflow flag, and compares every
// result word against the prediction under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shortest_superstring_length;
  import ssl_pkg::*;

  localparam int unsigned NSTR  = MAX_STRINGS_DEF;
  localparam int unsigned SLEN  = MAX_LEN_DEF;
  localparam int unsigned LIMIT = 20000000;

  // expected result tracking and set prediction
  class superstring_board;
    logic [7:0]       char_mem [NSTR*SLEN];
    logic [7:0]       str_len  [NSTR];
    int unsigned      str_cnt;
    logic [SUM_W-1:0] total_len;
    bit               ovf;
    int               ovl [NSTR][NSTR];
    int               best [1<<NSTR][NSTR];
    ssl_out_t         pending_results [$];
    int unsigned      errors, sets_seen, ovf_sets;

    function void clear_set();
      foreach (str_len[i]) str_len[i] = '0;
      str_cnt = 0;
      total_len = '0;
      ovf = 0;
    endfunction

    function int overlap_of(int a, int b);
      int la, lb, k, j;
      bit same;
      la = str_len[a];
      lb = str_len[b];
      for (k = (la < lb) ? la : lb; k > 0; k--) begin
        same = 1;
        for (j = 0; j < k; j++)
          if (char_mem[a*SLEN + la - k + j] != char_mem[b*SLEN + j]) same = 0;
        if (same) return k;
      end
      return 0;
    endfunction

    // best overlap sum over all orders, by subset dp
    function int best_order_sum();
      int m, i, j, full, r;
      full = (1 << str_cnt) - 1;
      for (m = 0; m <= full; m++)
        for (i = 0; i < NSTR; i++) best[m][i] = -1;
      for (i = 0; i < str_cnt; i++) best[1 << i][i] = 0;
      for (m = 1; m <= full; m++)
        for (i = 0; i < str_cnt; i++)
          if (best[m][i] >= 0)
            for (j = 0; j < str_cnt; j++)
              if (!m[j] && best[m | (1 << j)][j] < best[m][i] + ovl[i][j])
                best[m | (1 << j)][j] = best[m][i] + ovl[i][j];
      r = 0;
      for (i = 0; i < str_cnt; i++) if (best[full][i] > r) r = best[full][i];
      return r;
    endfunction

    function void note_word(ssl_in_t w);
      ssl_out_t res;
      if (!w.string_empty && str_cnt < NSTR) begin
        if (str_len[str_cnt] < SLEN) begin
          char_mem[str_cnt*SLEN + str_len[str_cnt]] = w.char_byte;
          str_len[str_cnt]++;
          total_len++;
        end else begin
          ovf = 1;
        end
      end
      if (w.string_empty || w.end_of_string || w.end_of_set) begin
        if (str_cnt < NSTR) str_cnt++;
        else ovf = 1;
      end
      if (w.end_of_set) begin
        for (int i = 0; i < str_cnt; i++)
          for (int j = 0; j < str_cnt; j++)
            ovl[i][j] = (i == j) ? 0 : overlap_of(i, j);
        res.superstring_length = total_len - SUM_W'(best_order_sum());
        if (ovf) res.superstring_length = '0;
        res.overflow_flag = ovf;
        pending_results.push_back(res);
        clear_set();
      end
    endfunction

    function void check_result(ssl_out_t got);
      ssl_out_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      sets_seen++;
      if (exp_res.overflow_flag) ovf_sets++;
      if (got.superstring_length !== exp_res.superstring_length) begin
        $error("superstring_length expected %0d actual %0d",
               exp_res.superstring_length, got.superstring_length);
        errors++;
      end
      if (got.overflow_flag !== exp_res.overflow_flag) begin
        $error("overflow_flag expected %0d actual %0d",
               exp_res.overflow_flag, got.overflow_flag);
        errors++;
      end
    endfunction
  endclass

  logic     clk, rst_n;
  logic     in_valid, in_ready, out_valid, out_ready;
  ssl_in_t  in_data;
  ssl_out_t out_data;
  bit       hold_off;
  bit       rx_done;
  superstring_board board;

  shortest_superstring_length dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // offer one word and wait until it is taken
  task send_word(ssl_in_t w);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task send_char(logic [7:0] c, bit eos, bit eoset);
    ssl_in_t w;
    w.char_byte = c;
    w.string_empty = 1'b0;
    w.end_of_string = eos;
    w.end_of_set = eoset;
    send_word(w);
  endtask

  task send_empty(bit eoset);
    ssl_in_t w;
    w.char_byte = 8'($urandom);
    w.string_empty = 1'b1;
    w.end_of_string = 1'($urandom);
    w.end_of_set = eoset;
    send_word(w);
  endtask

  // one string of given length, its end flagged; last also flags the set end
  task send_string(int n, bit last, bit wide);
    logic [7:0] c;
    if (n == 0) begin
      send_empty(last);
      return;
    end
    for (int i = 0; i < n; i++) begin
      c = wide ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h63));
      send_char(c, i == n - 1, last && i == n - 1);
    end
  endtask

  // random well-formed set, with an odd closing now and then
  task send_random_set();
    int n, r, len;
    bit wide;
    r = $urandom_range(0, 99);
    n = (r < 90) ? $urandom_range(1, 5) : $urandom_range(6, 7);
    wide = ($urandom_range(0, 9) == 0);
    // a little noise ahead of small sets
    if (n <= 2 && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) begin
        ssl_in_t w;
        w = ssl_in_t'($urandom);
        w.end_of_set = 1'b0;
        send_word(w);
      end
    for (int s = 0; s < n; s++) begin
      len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      r = $urandom_range(0, 9);
      if (r == 0 && len > 1) begin
        // set end without a string end on the last char
        for (int i = 0; i < len - 1; i++) send_char(8'($urandom_range(97, 99)), 0, 0);
        send_char(8'($urandom_range(97, 99)), 0, s == n - 1);
      end else if (r == 1 && len > 0) begin
        // partly loaded string closed by an empty word
        for (int i = 0; i < len; i++) send_char(8'($urandom_range(97, 99)), 0, 0);
        send_empty(s == n - 1);
      end else begin
        send_string(len, s == n - 1, wide);
      end
    end
  endtask

  // directed sets, then random sets
  initial begin
    board = new();
    board.clear_set();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // single string, extreme bytes
    send_char(8'h00, 0, 0);
    send_char(8'hff, 1, 1);
    // empty string, then an overlapping pair
    send_string(0, 0, 0);
    send_char(8'h41, 0, 0); send_char(8'h42, 1, 0);
    send_char(8'h42, 0, 0); send_char(8'h43, 1, 1);
    // lone empty string closes the set
    send_empty(1);
    // eight short strings, the most allowed
    for (int s = 0; s < NSTR; s++) send_string(2, s == NSTR - 1, 0);
    // nine strings: too many
    for (int s = 0; s <= NSTR; s++) send_string(1, s == NSTR, 0);
    // string at the length limit, then one past it
    for (int i = 0; i < SLEN; i++) send_char(8'h61, i == SLEN - 1, 0);
    send_char(8'h61, 1, 1);
    for (int i = 0; i <= SLEN; i++) send_char(8'($urandom), i == SLEN, i == SLEN);
    // random part
    hold_off = 1;
    while (board.sets_seen + board.pending_results.size() < 55) send_random_set();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    rx_done = 1;
  end

  // result side idling, with one long hold-off
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 0;
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : 1'b0;
      if ($urandom_range(0, 49) == 0) repeat ($urandom_range(5, 60)) @(negedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) board.check_result(out_data);

  // run control
  initial begin
    int unsigned cycles;
    rx_done = 0;
    cycles = 0;
    while (!rx_done && cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (!rx_done) begin
      $display("timeout after %0d cycles", cycles);
      $display("shortest_superstring_length: mismatch");
    end else begin
      $display("checked %0d string sets, %0d of them overflowing, in %0d cycles",
               board.sets_seen, board.ovf_sets, cycles);
      if (board.errors == 0 && board.pending_results.size() == 0)
        $display("shortest_superstring_length: match");
      else
        $display("shortest_superstring_length: mismatch");
    end
    $finish;
  end

endmodule
